// ===== sv/mvm_pkg.sv =====
// Shared types and constants for the matrix-vector multiply block.
// Word layouts, command codes, controller states and control structs.
// No dependencies.
`default_nettype none

package mvm_pkg;

  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product
  localparam int SUM_W  = 40;  // row accumulator
  localparam int ROW_W  = 6;   // reported row index
  localparam int SIZE_W = 7;   // matrix_size register

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Item command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [ELEM_W-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;  // vector load at accept
    logic rd_en;    // matrix word accepted, read vector entry
    logic mul_en;   // register the product
    logic acc_en;   // accumulate, step positions, emit on row end
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_end;   // current column is the last one
    logic out_busy;  // output word held and not taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/matrix_vector_multiply_top.sv =====
// Top level of the fixed-point matrix-vector multiply block.
// Depends on mvm_pkg, mvm_ctrl, mvm_datapath (and mvm_ram below it).
//
// Load the vector with cmd = load words, one Q8.8 element each, in order;
// every load restarts the matrix pass. Then stream matrix words (cmd =
// matrix) in row-major order; after each row's last column one output
// word carries the Q24.16 row sum (40 bits), the row index and a last-row
// flag. A vector load is written to the store when accepted. A matrix word
// passes three steps: the vector store read (registered RAM port), the
// 16x16 multiply and the 40-bit accumulate; at a row end the accumulate
// waits while the output register holds a word not taken on out_ready.
// One word is in flight at a time. The size register is written only
// while no word is in flight: cfg_ready is high only when the block is
// idle, and a pending size write holds off the input for that cycle. A
// size of 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Vector
// entries read before being written return unspecified data.
`default_nettype none

module matrix_vector_multiply_top #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire mvm_pkg::in_word_t            in_data,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      mvm_pkg::out_word_t           out_data,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [mvm_pkg::SIZE_W-1:0]   cfg_data
);

  mvm_pkg::ctrl_cmd_t  cmd;
  mvm_pkg::dp_status_t status;

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mvm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .in_value  (in_data.element_value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/mvm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mvm_ctrl.sv =====
// Sequencing state machine for the matrix-vector multiply block.
// Depends on mvm_pkg for states, command codes and control structs.
`default_nettype none

module mvm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  output      logic                in_ready,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire mvm_pkg::dp_status_t status,
  output      mvm_pkg::ctrl_cmd_t  cmd
);

  mvm_pkg::state_t state, state_next;
  logic            in_take;

  // A pending size write holds off the input word for that cycle
  assign in_take = in_valid && !cfg_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mvm_pkg::ST_IDLE: begin
        if (in_take && in_cmd == mvm_pkg::CMD_MATRIX) begin
          state_next = mvm_pkg::ST_READ;
        end
      end
      mvm_pkg::ST_READ: begin
        state_next = mvm_pkg::ST_MAC;
      end
      mvm_pkg::ST_MAC: begin
        // a row result waits for a free output register
        if (!(status.row_end && status.out_busy)) begin
          state_next = mvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mvm_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      mvm_pkg::ST_IDLE: begin
        in_ready    = !cfg_valid;
        cfg_ready   = 1'b1;
        cmd.load_we = in_take && in_cmd == mvm_pkg::CMD_LOAD;
        cmd.rd_en   = in_take && in_cmd == mvm_pkg::CMD_MATRIX;
      end
      mvm_pkg::ST_READ: begin
        cmd.mul_en = 1'b1;
      end
      mvm_pkg::ST_MAC: begin
        cmd.acc_en = !(status.row_end && status.out_busy);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // After acceptance a matrix word passes the read state, then reaches the accumulate step
  a_matrix_reaches_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> ##1 state == mvm_pkg::ST_MAC)
    else $error("matrix word did not reach accumulate step");

  // Only one item in flight: nothing accepted while work is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en || state == mvm_pkg::ST_MAC |-> !in_ready)
    else $error("input accepted while an item is in flight");

  // Size writes land only while idle and never beside an input word
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> state == mvm_pkg::ST_IDLE && !in_ready)
    else $error("size write accepted while busy");

endmodule

`default_nettype wire

// ===== sv/mvm_datapath.sv =====
// Datapath: vector store, position counters, multiplier, accumulator and
// output register. Depends on mvm_pkg and mvm_ram.
`default_nettype none

module mvm_datapath #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mvm_pkg::SIZE_W-1:0]        cfg_size,
  input  wire logic signed [mvm_pkg::ELEM_W-1:0] in_value,
  input  wire mvm_pkg::ctrl_cmd_t                cmd,
  output      mvm_pkg::dp_status_t               status,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      mvm_pkg::out_word_t                out_data
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int RESET_SIZE =
    (int'(mvm_pkg::SIZE_RESET) > MAX_DIM) ? MAX_DIM : int'(mvm_pkg::SIZE_RESET);

  logic [PW-1:0] last_idx, last_idx_next;
  logic [PW-1:0] load_pos;
  logic [PW-1:0] col_pos;
  logic [PW-1:0] row_pos;

  logic signed [mvm_pkg::ELEM_W-1:0] elem;
  logic [mvm_pkg::ELEM_W-1:0]        vec_rdata;
  logic signed [mvm_pkg::PROD_W-1:0] prod;
  logic signed [mvm_pkg::SUM_W-1:0]  acc;
  logic signed [mvm_pkg::SUM_W-1:0]  acc_sum;

  logic row_end;
  logic last_row;

  // Clamp the written size to 1..MAX_DIM, kept as last index
  always_comb begin
    if (cfg_size == '0) begin
      last_idx_next = '0;
    end else if (int'(cfg_size) > MAX_DIM) begin
      last_idx_next = PW'(MAX_DIM - 1);
    end else begin
      last_idx_next = PW'(int'(cfg_size) - 1);
    end
  end

  assign row_end  = col_pos == last_idx;
  assign last_row = row_pos == last_idx;
  assign acc_sum  = acc + mvm_pkg::SUM_W'(prod);

  assign status.row_end  = row_end;
  assign status.out_busy = out_valid && !out_ready;

  // Vector store
  mvm_ram #(
    .WIDTH (mvm_pkg::ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (load_pos),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (col_pos),
    .rdata (vec_rdata)
  );

  // Capture matrix element, then multiply
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      elem <= in_value;
    end
    if (cmd.mul_en) begin
      prod <= elem * $signed(vec_rdata);
    end
  end

  // Size, positions and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx <= PW'(RESET_SIZE - 1);
      load_pos <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      acc      <= '0;
    end else if (cfg_we) begin
      last_idx <= last_idx_next;
      load_pos <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      acc      <= '0;
    end else if (cmd.load_we) begin
      // each load restarts the matrix pass
      load_pos <= (load_pos == last_idx) ? '0 : load_pos + 1'b1;
      col_pos  <= '0;
      row_pos  <= '0;
      acc      <= '0;
    end else if (cmd.acc_en) begin
      if (row_end) begin
        acc     <= '0;
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_pos + 1'b1;
      end else begin
        acc     <= acc_sum;
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc_en && row_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && row_end) begin
      out_data.row_sum   <= acc_sum;
      out_data.row_index <= mvm_pkg::ROW_W'(row_pos);
      out_data.last_row  <= last_row;
    end
  end

  // A row result never overwrites a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_en && row_end |-> !(out_valid && !out_ready))
    else $error("row result overwrote a pending output word");

  // Positions stay inside the active size
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    col_pos <= last_idx && row_pos <= last_idx && load_pos <= last_idx)
    else $error("position counter beyond matrix size");

  // Mid-row accumulate steps the column by one
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_en && !row_end && !cfg_we |=> col_pos == $past(col_pos) + 1'b1)
    else $error("column position did not advance");

endmodule

`default_nettype wire

// ===== sim/matrix_vector_multiply_top_tb.sv =====
// Self-checking testbench for matrix_vector_multiply_top: random and directed
// vector/matrix words, size register changes between phases, row sums checked.
// Depends on mvm_pkg and the matrix_vector_multiply_top RTL.
`timescale 1ns / 100ps

module matrix_vector_multiply_top_tb;

  localparam int MAX_DIM      = 64;
  localparam int RANDOM_WORDS = 1650;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 300;
  localparam int SETTLE       = 8;

  // Idle schedule of the two sides
  typedef enum logic [1:0] {
    SENDER_LIGHT,  // sender idles 31%, receiver 62%
    SENDER_HEAVY,  // sender idles 62%, receiver 31%
    NO_IDLE
  } idle_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  mvm_pkg::in_word_t           in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  mvm_pkg::out_word_t          out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mvm_pkg::SIZE_W-1:0]  cfg_data  = '0;

  matrix_vector_multiply_top #(
    .MAX_DIM(MAX_DIM)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mvm_pkg::in_word_t          pending_words[$];
  mvm_pkg::out_word_t         expected_rows[$];
  logic [mvm_pkg::SIZE_W-1:0] size_writes[$];

  int words_accepted = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  // Predicted block state
  logic [mvm_pkg::SIZE_W-1:0]        size_reg = mvm_pkg::SIZE_RESET;
  logic signed [mvm_pkg::ELEM_W-1:0] vec_copy[MAX_DIM];
  int unsigned                       load_at  = 0;
  int unsigned                       col_at   = 0;
  int unsigned                       row_at   = 0;
  logic [mvm_pkg::SUM_W-1:0]         row_acc  = '0;

  // Stimulus-side tracking, so no matrix word ever reads an unwritten entry
  int unsigned gen_size    = MAX_DIM;
  int unsigned gen_load_at = 0;
  bit          gen_written[MAX_DIM];
  int          words_queued = 0;

  function automatic int unsigned active_size(input logic [mvm_pkg::SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic idle_mix_t idle_mix();
    if (words_accepted < 560) return SENDER_LIGHT;
    if (words_accepted < 1120) return SENDER_HEAVY;
    return NO_IDLE;
  endfunction

  function automatic bit sender_idles();
    case (idle_mix())
      SENDER_LIGHT: return $urandom_range(0, 99) < 31;
      SENDER_HEAVY: return $urandom_range(0, 99) < 62;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mix())
      SENDER_LIGHT: return $urandom_range(0, 99) < 62;
      SENDER_HEAVY: return $urandom_range(0, 99) < 31;
      default:      return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  task automatic restart_pass();
    col_at  = 0;
    row_at  = 0;
    row_acc = '0;
  endtask

  task automatic apply_size(input logic [mvm_pkg::SIZE_W-1:0] v);
    size_reg = v;
    load_at  = 0;
    restart_pass();
  endtask

  // Multiply-accumulate one accepted word; queue a row sum at each row end
  task automatic accumulate_word(input mvm_pkg::in_word_t w);
    int unsigned                       n;
    logic signed [mvm_pkg::ELEM_W-1:0] a;
    logic signed [mvm_pkg::ELEM_W-1:0] b;
    logic signed [mvm_pkg::PROD_W-1:0] prod;
    mvm_pkg::out_word_t                row;
    n = active_size(size_reg);
    a = w.element_value;
    if (w.cmd == mvm_pkg::CMD_LOAD) begin
      if (load_at >= n) load_at = 0;
      vec_copy[load_at] = a;
      load_at++;
      if (load_at >= n) load_at = 0;
      restart_pass();
    end else begin
      if (col_at >= n || row_at >= n) restart_pass();
      b       = vec_copy[col_at];
      prod    = a * b;
      row_acc = row_acc +
                {{(mvm_pkg::SUM_W-mvm_pkg::PROD_W){prod[mvm_pkg::PROD_W-1]}}, prod};
      if (col_at + 1 < n) begin
        col_at++;
      end else begin
        row.row_sum   = row_acc;
        row.row_index = row_at[mvm_pkg::ROW_W-1:0];
        row.last_row  = (row_at + 1 == n);
        expected_rows.push_back(row);
        row_acc = '0;
        col_at  = 0;
        row_at++;
        if (row_at >= n) row_at = 0;
      end
    end
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_word(in_data);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && !sender_idles()) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Size register driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_size(cfg_data);
      if (!cfg_valid || cfg_ready) begin
        if (size_writes.size() != 0) begin
          cfg_data  <= size_writes.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected row word, row_index %0d",
                                    out_data.row_index));
        end else begin
          if (out_data.row_sum !== expected_rows[0].row_sum)
            report_mismatch($sformatf("row %0d row_sum %0d, expected %0d",
                                      expected_rows[0].row_index, out_data.row_sum,
                                      expected_rows[0].row_sum));
          if (out_data.row_index !== expected_rows[0].row_index)
            report_mismatch($sformatf("row_index %0d, expected %0d",
                                      out_data.row_index, expected_rows[0].row_index));
          if (out_data.last_row !== expected_rows[0].last_row)
            report_mismatch($sformatf("row %0d last_row %0b, expected %0b",
                                      expected_rows[0].row_index, out_data.last_row,
                                      expected_rows[0].last_row));
          void'(expected_rows.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_idles();
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL matrix_vector_multiply_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus helpers
  function automatic logic signed [mvm_pkg::ELEM_W-1:0] rand_elem();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h8000;
    if (r < 16) return 16'h7FFF;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return mvm_pkg::ELEM_W'($urandom);
  endfunction

  function automatic bit vector_ready();
    for (int i = 0; i < gen_size; i++)
      if (!gen_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_load(input logic signed [mvm_pkg::ELEM_W-1:0] v);
    if (gen_load_at >= gen_size) gen_load_at = 0;
    gen_written[gen_load_at] = 1'b1;
    gen_load_at++;
    if (gen_load_at >= gen_size) gen_load_at = 0;
    pending_words.push_back('{cmd: mvm_pkg::CMD_LOAD, element_value: v});
    words_queued++;
  endtask

  task automatic send_element(input logic signed [mvm_pkg::ELEM_W-1:0] v);
    pending_words.push_back('{cmd: mvm_pkg::CMD_MATRIX, element_value: v});
    words_queued++;
  endtask

  task automatic load_vector(input int unsigned count);
    repeat (count) send_load(rand_elem());
  endtask

  task automatic stream_elements(input int unsigned count);
    repeat (count) send_element(rand_elem());
  endtask

  // Wait until every word is in and every row sum is out, then settle
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_rows.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [mvm_pkg::SIZE_W-1:0] v);
    gen_size    = active_size(v);
    gen_load_at = 0;
    size_writes.push_back(v);
    do @(posedge clk);
    while (size_writes.size() != 0 || cfg_valid);
  endtask

  initial begin
    int unsigned                n;
    int unsigned                r;
    int                         phase_start;
    int                         budget;
    int                         phase_no;
    logic [mvm_pkg::SIZE_W-1:0] v;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Size 0 acts as 1: single-element dot products at the operand extremes
    write_size('0);
    send_load(16'h8000);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element('0);
    send_load(16'h7FFF);
    send_element(16'h7FFF);
    send_element('1);
    drain();

    // 3x3: full pass, wrap into a second pass, then a load mid-pass restarts it
    write_size(7'd3);
    send_load(16'h7FFF);
    send_load(16'h8000);
    send_load(16'h0001);
    repeat (3) send_element(16'h8000);
    repeat (3) send_element(16'h7FFF);
    send_element(16'h0100);
    send_element('1);
    send_element('0);
    send_element(16'h7FFF);
    send_element(16'h8000);
    send_load(16'h0100);
    repeat (3) send_element(16'h0100);
    drain();

    // Random phases: mostly small sizes, a few large ones
    words_queued = 0;
    phase_no     = 0;
    while (words_queued < RANDOM_WORDS) begin
      case (phase_no)
        0:       v = 7'd127;
        1:       v = 7'd1;
        2:       v = 7'd2;
        3:       v = 7'd64;
        4:       v = 7'd0;
        default: v = ($urandom_range(0, 99) < 10) ? 7'($urandom_range(9, 127))
                                                  : 7'($urandom_range(2, 8));
      endcase
      phase_no++;
      write_size(v);
      n           = gen_size;
      budget      = (n <= 8) ? 110 : 200;
      phase_start = words_queued;
      while (words_queued - phase_start < budget) begin
        r = $urandom_range(0, 99);
        if (!vector_ready() || r < 30) begin
          // short loads are the broken sequences
          load_vector((r < 10) ? $urandom_range(1, n) : n);
        end else if (r < 40) begin
          stream_elements($urandom_range(1, 2 * n));
        end else if (n <= 8) begin
          stream_elements(n * n * $urandom_range(1, 3));
        end else begin
          stream_elements(n * $urandom_range(1, 2));
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS matrix_vector_multiply_top");
    end else begin
      $display("FAIL matrix_vector_multiply_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mvm_pkg.sv
sv/mvm_ram.sv
sv/mvm_ctrl.sv
sv/mvm_datapath.sv
sv/matrix_vector_multiply_top.sv
sim/matrix_vector_multiply_top_tb.sv
